// ===== sv/dhp_pkg.sv =====
// ----------------------------------------------------------------------------
// dhp_pkg
// Shared types, constants and seed functions of the delayed helicity predictor.
// ----------------------------------------------------------------------------
package dhp_pkg;

    localparam int SEED_BITS        = 24;
    localparam int SEED_LOAD_STEPS  = SEED_BITS + 1;
    localparam int MAX_MISSED_DEF   = 30;
    localparam int CNT_W            = 6;
    localparam int DIV_STEPS        = 34;

    localparam int CFG_IDX_W        = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIGN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOL    = 2'd3;

    localparam logic [7:0]  RST_DELAY  = 8'd0;
    localparam logic [1:0]  RST_SIGN   = 2'b11;
    localparam logic [15:0] RST_PERIOD = 16'd14050;
    localparam logic [15:0] RST_TOL    = 16'd20;

    // helicity values, two bit signed
    localparam logic [1:0] VAL_PLUS  = 2'b01;
    localparam logic [1:0] VAL_MINUS = 2'b11;
    localparam logic [1:0] VAL_NONE  = 2'b00;

    localparam logic [4:0] CNT_FULL  = 5'd24;
    localparam logic [4:0] CNT_DONE  = 5'd25;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAP_CHK,
        ST_GAP_CNT,
        ST_GAP_LOOP,
        ST_GAP_QS,
        ST_GAP_ADV,
        ST_FIRST,
        ST_DIV,
        ST_ORIGIN,
        ST_MAIN_QS,
        ST_SEED,
        ST_DELAY,
        ST_BUILD_DONE,
        ST_CHECK,
        ST_TQ,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic load;
        logic gap_init;
        logic gap_sub;
        logic gap_fail;
        logic gap_adv;
        logic tq_recalc;
        logic first_q;
        logic div_init;
        logic div_step;
        logic origin_set;
        logic qs_begin;
        logic qs_forced;
        logic seed_both;
        logic seed_hel;
        logic build_done;
        logic check;
        logic final_out;
    } t_cmd;

    typedef struct packed {
        logic             gap_hit;
        logic             miss_max;
        logic             miss_zero;
        logic             rem_ge;
        logic             main_q;
        logic             qs_build;
        logic             out_free;
        logic [CNT_W-1:0] delay_quads;
    } t_status;

    function automatic logic [SEED_BITS-1:0] seed_step(input logic [SEED_BITS-1:0] s);
        logic top;
        top = s[SEED_BITS-1];
        return {s[SEED_BITS-2:0] ^ {{(SEED_BITS-5){1'b0}}, top, top, 1'b0, top}, top};
    endfunction

    function automatic logic [1:0] seed_val(input logic [SEED_BITS-1:0] s);
        return s[SEED_BITS-1] ? VAL_PLUS : VAL_MINUS;
    endfunction

    // readings come in oldest first; the last four undo the feedback taps
    function automatic logic [SEED_BITS-1:0] build_seed(input logic [SEED_BITS-1:0] g);
        logic [SEED_BITS-1:0] b;
        for (int i = 0; i < 20; i++) begin
            b[23-i] = g[i];
        end
        b[3] = g[20] ^ b[23];
        b[2] = g[21] ^ b[22] ^ b[23];
        b[1] = g[22] ^ b[21] ^ b[22];
        b[0] = g[23] ^ b[20] ^ b[21] ^ b[23];
        return b;
    endfunction

endpackage

// ===== sv/dhp_datapath.sv =====
// ----------------------------------------------------------------------------
// dhp_datapath
// Timing, seed and helicity registers of the predictor, driven by commands.
// ----------------------------------------------------------------------------
module dhp_datapath import dhp_pkg::*; #(
    parameter int MAX_MISSED = MAX_MISSED_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [31:0]          i_event_time,
    input  logic                 i_quad_start,
    input  logic                 i_gate_on,
    input  logic                 i_reading_bit,
    input  logic                 i_sync_event,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_helicity,
    output logic                 o_helicity_valid,
    output logic                 o_prediction_failed,
    output logic                 o_gap_reset
);

    localparam int MW = $clog2(MAX_MISSED + 1);

    logic [7:0]  r_delay;
    logic [1:0]  r_sign;
    logic [15:0] r_qperiod;
    logic [15:0] r_tol;

    logic [31:0] r_t;
    logic        r_qrt, r_gate, r_rd, r_sync_ev;
    logic [33:0] r_tq;
    logic [33:0] r_rem;
    logic [MW-1:0] r_miss;
    logic [33:0] r_dvd;
    logic [16:0] r_drem;
    logic        r_neg;

    logic [33:0] r_origin;
    logic [31:0] r_sync;
    logic [31:0] r_last;
    logic        r_waiting, r_restart, r_cal;
    logic [SEED_BITS-1:0] r_gbits;
    logic [4:0]  r_count;
    logic [SEED_BITS-1:0] r_rseed, r_hseed;
    logic [1:0]  r_pred, r_saved, r_present, r_qfv;
    logic        r_qfr;
    logic [2:0]  r_pos;
    logic        r_failed, r_gap;

    logic        r_out_valid;
    logic [1:0]  r_out_hel;
    logic        r_out_cal, r_out_failed, r_out_gap;

    logic [15:0] w_p;
    logic [17:0] w_p4;
    logic [19:0] w_glim;
    logic [17:0] w_p3;
    logic [31:0] w_dlast;
    logic [35:0] w_dlast_x, w_d10;
    logic        w_guard;
    logic [4:0]  w_eff_cnt;
    logic [31:0] w_dsync;
    logic [33:0] w_num;
    logic [16:0] w_trial;
    logic [16:0] w_shift;
    logic [15:0] w_r;
    logic [37:0] w_tq_x, w_tq10;
    logic [19:0] w_p16;
    logic [21:0] w_p36, w_p44;
    logic        w_f16, w_f36, w_f44;
    logic [2:0]  w_pos;
    logic [1:0]  w_pres;
    logic [1:0]  w_hel;
    logic        w_step_ok;

    assign w_p    = (r_qperiod == 16'd0) ? 16'd1 : r_qperiod;
    assign w_p4   = {w_p, 2'b00};
    assign w_glim = {4'b0, w_p} + {2'b0, w_p, 2'b00} + {2'b0, r_tol, 2'b00};
    assign w_p3   = {2'b0, w_p} + {1'b0, w_p, 1'b0};

    assign w_dlast   = r_t - r_last;
    assign w_dlast_x = {{4{w_dlast[31]}}, w_dlast};
    assign w_d10     = {w_dlast_x[32:0], 3'b000} + {w_dlast_x[34:0], 1'b0};
    assign w_guard   = $signed(w_d10) < $signed({18'b0, w_p3});
    assign w_eff_cnt = r_restart ? 5'd0 : r_count;
    assign w_step_ok = i_cmd.qs_forced || !w_guard;

    assign w_dsync = r_t - r_sync;
    assign w_num   = {w_dsync, 2'b00};
    // restoring step: shift in the next dividend bit, subtract when it fits
    assign w_trial = {r_drem[15:0], r_dvd[33]};
    assign w_shift = (w_trial >= {1'b0, w_p}) ? (w_trial - {1'b0, w_p}) : w_trial;
    assign w_r     = (r_neg && r_drem[15:0] != 16'd0) ? (w_p - r_drem[15:0]) : r_drem[15:0];

    assign w_tq_x  = {{4{r_tq[33]}}, r_tq};
    assign w_tq10  = {w_tq_x[34:0], 3'b000} + {w_tq_x[36:0], 1'b0};
    assign w_p16   = {w_p, 4'b0000};
    assign w_p36   = {1'b0, w_p, 5'b00000} + {4'b0, w_p, 2'b00};
    assign w_p44   = {1'b0, w_p, 5'b00000} + {3'b0, w_p, 3'b000} + {4'b0, w_p, 2'b00};
    assign w_f16   = $signed(w_tq10) < $signed({18'b0, w_p16});
    assign w_f36   = $signed(w_tq10) < $signed({16'b0, w_p36});
    assign w_f44   = $signed(w_tq10) < $signed({16'b0, w_p44});

    always_comb begin
        w_pos  = r_pos;
        w_pres = r_present;
        if (!r_cal || !r_gate) begin
            w_pres = VAL_NONE;
        end else begin
            if (w_f16 && r_qrt) w_pos = 3'd1;
            if (w_f36 && !r_qrt && r_rd != r_qfr) w_pos = 3'd2;
            if (w_f44 && !r_qrt && r_rd == r_qfr) w_pos = 3'd4;
            if (w_pos == 3'd1 || w_pos >= 3'd4) begin
                w_pres = r_qfv;
            end else if (r_qfv == VAL_PLUS) begin
                w_pres = VAL_MINUS;
            end else if (r_qfv == VAL_MINUS) begin
                w_pres = VAL_PLUS;
            end
        end
    end

    // sign pattern 10 acts as minus one
    always_comb begin
        if (r_sign[1]) begin
            w_hel = 2'(-w_pres);
        end else if (r_sign[0]) begin
            w_hel = w_pres;
        end else begin
            w_hel = VAL_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay   <= RST_DELAY;
            r_sign    <= RST_SIGN;
            r_qperiod <= RST_PERIOD;
            r_tol     <= RST_TOL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX_DELAY:  r_delay   <= i_cfg_data[7:0];
                CFG_IDX_SIGN:   r_sign    <= i_cfg_data[1:0];
                CFG_IDX_PERIOD: r_qperiod <= i_cfg_data;
                CFG_IDX_TOL:    r_tol     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-event scratch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t       <= i_event_time;
            r_qrt     <= i_quad_start;
            r_gate    <= i_gate_on;
            r_rd      <= i_reading_bit;
            r_sync_ev <= i_sync_event;
            r_tq      <= {i_event_time, 2'b00} - r_origin;
        end else if (i_cmd.tq_recalc) begin
            r_tq      <= {r_t, 2'b00} - r_origin;
        end
        if (i_cmd.div_init) begin
            r_neg  <= w_num[33];
            r_dvd  <= w_num[33] ? 34'(-w_num) : w_num;
            r_drem <= 17'd0;
        end else if (i_cmd.div_step) begin
            r_drem <= w_shift;
            r_dvd  <= {r_dvd[32:0], 1'b0};
        end
        if (i_cmd.gap_init) begin
            r_rem <= r_tq;
        end else if (i_cmd.gap_sub) begin
            r_rem <= r_rem - {16'b0, w_p4};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin  <= '0;
            r_sync    <= '0;
            r_last    <= '0;
            r_waiting <= 1'b1;
            r_restart <= 1'b1;
            r_cal     <= 1'b0;
            r_gbits   <= '0;
            r_count   <= '0;
            r_rseed   <= '0;
            r_hseed   <= '0;
            r_pred    <= VAL_NONE;
            r_saved   <= VAL_NONE;
            r_present <= VAL_NONE;
            r_qfv     <= VAL_NONE;
            r_qfr     <= 1'b0;
            r_pos     <= '0;
            r_failed  <= 1'b0;
            r_gap     <= 1'b0;
            r_miss    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_present <= VAL_NONE;
                r_failed  <= 1'b0;
                r_gap     <= 1'b0;
            end
            if (i_cmd.gap_init) r_miss <= '0;
            if (i_cmd.gap_sub)  r_miss <= r_miss + MW'(1);
            if (i_cmd.gap_fail) begin
                r_restart <= 1'b1;
                r_cal     <= 1'b0;
                r_waiting <= 1'b1;
                r_gap     <= 1'b1;
            end
            if (i_cmd.gap_adv) begin
                r_origin <= r_origin + {16'b0, w_p4};
                r_qfv    <= r_present;
                r_miss   <= r_miss - MW'(1);
            end
            if (i_cmd.first_q) begin
                if (r_qrt && r_waiting) begin
                    r_origin  <= {r_t, 2'b00};
                    r_waiting <= 1'b0;
                end
                if (r_sync_ev && !r_qrt) r_sync <= r_t;
            end
            if (i_cmd.origin_set) begin
                r_origin <= {r_t, 2'b00} - {18'b0, w_r};
                r_qfr    <= r_rd;
            end
            if (i_cmd.qs_begin) begin
                r_restart <= 1'b0;
                if (w_eff_cnt < CNT_FULL) begin
                    r_gbits[w_eff_cnt] <= r_rd;
                    r_count <= w_eff_cnt + 5'd1;
                    r_cal   <= 1'b0;
                end else if (w_eff_cnt == CNT_FULL) begin
                    r_rseed <= build_seed(r_gbits);
                    r_hseed <= build_seed(r_gbits);
                end else if (w_step_ok) begin
                    r_rseed   <= seed_step(r_rseed);
                    r_hseed   <= seed_step(r_hseed);
                    r_pred    <= seed_val(r_rseed);
                    r_present <= seed_val(r_hseed);
                    r_saved   <= seed_val(r_hseed);
                    r_last    <= r_t;
                    r_cal     <= 1'b1;
                end else begin
                    r_present <= r_saved;
                end
            end
            if (i_cmd.seed_both) begin
                r_rseed   <= seed_step(r_rseed);
                r_hseed   <= seed_step(r_hseed);
                r_pred    <= seed_val(r_rseed);
                r_present <= seed_val(r_rseed);
            end
            if (i_cmd.seed_hel) begin
                r_hseed   <= seed_step(r_hseed);
                r_present <= seed_val(r_hseed);
            end
            if (i_cmd.build_done) begin
                r_count <= CNT_DONE;
                r_saved <= r_present;
                r_cal   <= 1'b1;
            end
            if (i_cmd.check) begin
                r_qfv <= r_present;
                if (r_cal && !((!r_rd && r_pred == VAL_MINUS) || (r_rd && r_pred == VAL_PLUS)))
                begin
                    r_restart <= 1'b1;
                    r_cal     <= 1'b0;
                    r_waiting <= 1'b1;
                    r_present <= VAL_NONE;
                    r_failed  <= 1'b1;
                end
            end
            if (i_cmd.final_out) begin
                r_pos     <= w_pos;
                r_present <= w_pres;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.final_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.final_out) begin
            r_out_hel    <= w_hel;
            r_out_cal    <= r_cal;
            r_out_failed <= r_failed;
            r_out_gap    <= r_gap;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_helicity          = r_out_hel;
    assign o_helicity_valid    = r_out_cal;
    assign o_prediction_failed = r_out_failed;
    assign o_gap_reset         = r_out_gap;

    assign o_status.gap_hit     = !r_waiting && ($signed(r_tq) > $signed({14'b0, w_glim}));
    assign o_status.miss_max    = (r_miss == MW'(MAX_MISSED));
    assign o_status.miss_zero   = (r_miss == '0);
    assign o_status.rem_ge      = (r_rem >= {16'b0, w_p4});
    assign o_status.main_q      = r_qrt && ($signed(r_tq) > $signed({17'b0, w_p, 1'b0}));
    assign o_status.qs_build    = (w_eff_cnt == CNT_FULL);
    assign o_status.out_free    = !r_out_valid || i_out_ready;
    assign o_status.delay_quads = r_delay[7:2];

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_DONE)
        else $error("gathered count out of range");

    a_reset_uncal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_failed || r_out_gap) |-> !r_out_cal)
        else $error("predictor reset but result marked calibrated");

    a_uncal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_cal |-> r_out_hel == VAL_NONE)
        else $error("helicity reported while uncalibrated");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.div_step) |-> r_drem < {1'b0, w_p})
        else $error("division remainder not below period");

endmodule

// ===== sv/dhp_ctrl.sv =====
// ----------------------------------------------------------------------------
// dhp_ctrl
// Sequencer of the predictor: gap recovery, realignment, seed rebuild, output.
// ----------------------------------------------------------------------------
module dhp_ctrl import dhp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ctx_gap, n_ctx_gap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_ctx_gap <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_ctx_gap <= n_ctx_gap;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ctx_gap = r_ctx_gap;
        case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_GAP_CHK;
            ST_GAP_CHK: n_state = i_status.gap_hit ? ST_GAP_CNT : ST_FIRST;
            ST_GAP_CNT: begin
                if (i_status.miss_max) begin
                    n_state = ST_FIRST;
                end else if (!i_status.rem_ge) begin
                    n_state = ST_GAP_LOOP;
                end
            end
            ST_GAP_LOOP: n_state = i_status.miss_zero ? ST_FIRST : ST_GAP_QS;
            ST_GAP_QS: begin
                n_ctx_gap = 1'b1;
                if (i_status.qs_build) begin
                    n_cnt   = CNT_W'(SEED_LOAD_STEPS - 1);
                    n_state = ST_SEED;
                end else begin
                    n_state = ST_GAP_ADV;
                end
            end
            ST_GAP_ADV: n_state = ST_GAP_LOOP;
            ST_FIRST: begin
                if (i_status.main_q) begin
                    n_cnt   = CNT_W'(DIV_STEPS - 1);
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_TQ;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) n_state = ST_ORIGIN;
            end
            ST_ORIGIN: n_state = ST_MAIN_QS;
            ST_MAIN_QS: begin
                n_ctx_gap = 1'b0;
                if (i_status.qs_build) begin
                    n_cnt   = CNT_W'(SEED_LOAD_STEPS - 1);
                    n_state = ST_SEED;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_SEED: begin
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    if (i_status.delay_quads == '0) begin
                        n_state = ST_BUILD_DONE;
                    end else begin
                        n_cnt   = i_status.delay_quads - CNT_W'(1);
                        n_state = ST_DELAY;
                    end
                end
            end
            ST_DELAY: begin
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) n_state = ST_BUILD_DONE;
            end
            ST_BUILD_DONE: n_state = r_ctx_gap ? ST_GAP_ADV : ST_CHECK;
            ST_CHECK:      n_state = ST_TQ;
            ST_TQ:         n_state = ST_FINAL;
            ST_FINAL:      if (i_status.out_free) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_GAP_CHK: o_cmd.gap_init = i_status.gap_hit;
            ST_GAP_CNT: begin
                if (i_status.miss_max) begin
                    o_cmd.gap_fail = 1'b1;
                end else if (i_status.rem_ge) begin
                    o_cmd.gap_sub = 1'b1;
                end
            end
            ST_GAP_LOOP: o_cmd.tq_recalc = i_status.miss_zero;
            ST_GAP_QS: begin
                o_cmd.qs_begin  = 1'b1;
                o_cmd.qs_forced = 1'b1;
            end
            ST_GAP_ADV: o_cmd.gap_adv = 1'b1;
            ST_FIRST: begin
                o_cmd.first_q  = 1'b1;
                o_cmd.div_init = i_status.main_q;
            end
            ST_DIV:        o_cmd.div_step   = 1'b1;
            ST_ORIGIN:     o_cmd.origin_set = 1'b1;
            ST_MAIN_QS:    o_cmd.qs_begin   = 1'b1;
            ST_SEED:       o_cmd.seed_both  = 1'b1;
            ST_DELAY:      o_cmd.seed_hel   = 1'b1;
            ST_BUILD_DONE: o_cmd.build_done = 1'b1;
            ST_CHECK:      o_cmd.check      = 1'b1;
            ST_TQ:         o_cmd.tq_recalc  = 1'b1;
            ST_FINAL:      o_cmd.final_out  = i_status.out_free;
            default: ;
        endcase
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_GAP_CHK)
        else $error("load did not start the sequence");

    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.final_out |=> r_state == ST_IDLE)
        else $error("result written without returning to idle");

    a_build_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_BUILD_DONE |-> $past(r_state) == ST_SEED || $past(r_state) == ST_DELAY)
        else $error("seed rebuild finished without stepping");

endmodule

// ===== sv/delayed_helicity_predictor.sv =====
// ----------------------------------------------------------------------------
// delayed_helicity_predictor
// Quad-synchronous 24-bit helicity sequence predictor with delay compensation.
// ----------------------------------------------------------------------------
// sequence: a request passes the gap check, first-quad, time-quad and final states; a main
//   quad start adds a bit-serial realignment division, origin set, quad step and check; a
//   seed rebuild adds seed loading and helicity-only steps for the whole quads of the delay
// throughput: one event at a time, next request taken the cycle after the result
//   is latched; a stalled result holds off the next request
// reset: synchronous, clears control and predictor state and loads register defaults, no sweep
module delayed_helicity_predictor import dhp_pkg::*; #(
    parameter int MAX_MISSED_QUADS = MAX_MISSED_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // event_time[31:0], quad_start[32], gate_on[33], reading_bit[34], zero pad
    input  logic [39:0]          s_axis_tdata,
    // sync_event[0]
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // helicity[1:0], helicity_valid[2], prediction_failed[3], gap_reset[4], zero pad
    output logic [7:0]           m_axis_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    t_cmd       w_cmd;
    t_status    w_status;
    logic [1:0] w_hel;
    logic       w_cal, w_failed, w_gap;

    assign o_cfg_ready = 1'b1;

    dhp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dhp_datapath #(
        .MAX_MISSED (MAX_MISSED_QUADS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_event_time        (s_axis_tdata[31:0]),
        .i_quad_start        (s_axis_tdata[32]),
        .i_gate_on           (s_axis_tdata[33]),
        .i_reading_bit       (s_axis_tdata[34]),
        .i_sync_event        (s_axis_tuser),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_out_valid         (m_axis_tvalid),
        .i_out_ready         (m_axis_tready),
        .o_helicity          (w_hel),
        .o_helicity_valid    (w_cal),
        .o_prediction_failed (w_failed),
        .o_gap_reset         (w_gap)
    );

    assign m_axis_tdata = {3'b000, w_gap, w_failed, w_cal, w_hel};

endmodule

// ===== tb/sv/delayed_helicity_predictor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delayed_helicity_predictor_tb
// Streams timestamped events through the helicity predictor and checks every
// result against a scoreboard that tracks seed gathering, rebuild, stepping,
// gap bridging and in-quad helicity.
// ----------------------------------------------------------------------------
module delayed_helicity_predictor_tb import dhp_pkg::*;;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  DRAIN_WAIT  = 400;
    localparam bit [23:0] TAPS  = 24'h80000D;

    typedef struct {
        logic [1:0] hel;
        bit         valid;
        bit         failed;
        bit         gap;
    } t_hel_result;

    class helicity_scoreboard;
        bit [7:0]  delay_w;
        bit [1:0]  sign_bits;
        bit [15:0] period;
        bit [15:0] tol;
        bit [33:0] origin;
        bit [31:0] sync_t;
        bit [31:0] last_t;
        bit        waiting;
        bit        restart;
        bit        gathered [24];
        int        gcount;
        bit [23:0] rseed;
        bit [23:0] hseed;
        int        predicted;
        int        saved;
        int        present;
        bit        first_rd;
        int        first_val;
        bit        calibrated;
        bit [2:0]  pos;
        t_hel_result results_due[$];
        int        errors;

        function new();
            delay_w = RST_DELAY;
            sign_bits = RST_SIGN;
            period = RST_PERIOD;
            tol = RST_TOL;
            origin = '0;
            sync_t = '0;
            last_t = '0;
            waiting = 1'b1;
            restart = 1'b1;
            foreach (gathered[i]) gathered[i] = 1'b0;
            gcount = 0;
            rseed = '0;
            hseed = '0;
            predicted = 0;
            saved = 0;
            present = 0;
            first_rd = 1'b0;
            first_val = 0;
            calibrated = 1'b0;
            pos = '0;
            errors = 0;
        endfunction

        function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [15:0] d);
            case (idx)
                CFG_IDX_DELAY:  delay_w = d[7:0];
                CFG_IDX_SIGN:   sign_bits = d[1:0];
                CFG_IDX_PERIOD: period = d;
                CFG_IDX_TOL:    tol = d;
                default: ;
            endcase
        endfunction

        function longint eff_period();
            return (period == 0) ? 64'sd1 : longint'(period);
        endfunction

        function longint tdiff(bit [31:0] a, bit [31:0] b);
            bit [31:0] u;
            u = a - b;
            return longint'($signed(u));
        endfunction

        function longint origin_dist(bit [31:0] t);
            bit [33:0] u;
            u = {t, 2'b00} - origin;
            return longint'($signed(u));
        endfunction

        function int advance(ref bit [23:0] s);
            if (s[23]) begin
                s = ((s ^ TAPS) << 1) | 24'd1;
                return 1;
            end
            s = s << 1;
            return -1;
        endfunction

        function bit [23:0] seed_from_readings();
            bit [23:0] b;
            for (int i = 0; i < 20; i++) b[23-i] = gathered[i];
            b[3] = gathered[20] ^ b[23];
            b[2] = gathered[21] ^ b[22] ^ b[23];
            b[1] = gathered[22] ^ b[21] ^ b[22];
            b[0] = gathered[23] ^ b[20] ^ b[21] ^ b[23];
            return b;
        endfunction

        function void quad_advance(bit forced, bit [31:0] t, bit rd);
            int dummy;
            if (restart) gcount = 0;
            restart = 1'b0;
            if (gcount < SEED_BITS) begin
                gathered[gcount] = rd;
                gcount++;
                calibrated = 1'b0;
            end else if (gcount == SEED_BITS) begin
                rseed = seed_from_readings();
                hseed = rseed;
                for (int i = 0; i < SEED_BITS + 1; i++) begin
                    predicted = advance(rseed);
                    dummy = advance(hseed);
                end
                present = predicted;
                for (int i = 0; i < delay_w / 4; i++) present = advance(hseed);
                gcount++;
                saved = present;
                calibrated = 1'b1;
            end else begin
                present = saved;
                if (!forced && 10 * tdiff(t, last_t) < 3 * eff_period()) return;
                predicted = advance(rseed);
                present = advance(hseed);
                saved = present;
                last_t = t;
                calibrated = 1'b1;
            end
        endfunction

        function void note_event(bit [31:0] t, bit q, bit g, bit rd, bit s);
            longint p;
            longint tq;
            longint missed;
            longint num;
            longint k;
            bit failed;
            bit gap;
            int sgn;
            int hv;
            t_hel_result r;
            p = eff_period();
            tq = origin_dist(t);
            failed = 1'b0;
            gap = 1'b0;
            present = 0;
            if (!waiting && tq > 5 * p + 4 * longint'(tol)) begin
                missed = tq / (4 * p);
                if (missed < MAX_MISSED_DEF) begin
                    for (longint i = 0; i < missed; i++) begin
                        quad_advance(1'b1, t, rd);
                        origin = origin + 34'(4 * p);
                        first_val = present;
                    end
                    tq = origin_dist(t);
                end else begin
                    restart = 1'b1;
                    calibrated = 1'b0;
                    waiting = 1'b1;
                    gap = 1'b1;
                end
            end
            if (q && waiting) begin
                origin = {t, 2'b00};
                waiting = 1'b0;
            end
            if (s && !q) sync_t = t;
            if (q && tq > 2 * p) begin
                num = 4 * tdiff(t, sync_t);
                k = num / p;
                if ((num % p) != 0 && num < 0) k--;
                origin = 34'(k * p) + {sync_t, 2'b00};
                first_rd = rd;
                quad_advance(1'b0, t, rd);
                first_val = present;
                // the fresh reading must match what the sequence predicted
                if (calibrated && !((rd == 0 && predicted == -1) || (rd == 1 && predicted == 1)))
                begin
                    restart = 1'b1;
                    calibrated = 1'b0;
                    waiting = 1'b1;
                    present = 0;
                    failed = 1'b1;
                end
            end
            tq = origin_dist(t);
            if (!calibrated || !g) begin
                present = 0;
            end else begin
                if (10 * tq < 16 * p && q) pos = 1;
                if (10 * tq < 36 * p && !q && rd != first_rd) pos = 2;
                if (10 * tq < 44 * p && !q && rd == first_rd) pos = 4;
                if (pos == 1 || pos >= 4) begin
                    present = first_val;
                end else if (first_val == 1) begin
                    present = -1;
                end else if (first_val == -1) begin
                    present = 1;
                end
            end
            sgn = sign_bits[1] ? -1 : int'(sign_bits);
            hv = sgn * present;
            r.hel = hv[1:0];
            r.valid = calibrated;
            r.failed = failed;
            r.gap = gap;
            results_due.push_back(r);
        endfunction

        function void check_result(logic [7:0] d);
            t_hel_result r;
            if (results_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", d);
                return;
            end
            r = results_due.pop_front();
            if (d !== {3'b000, r.gap, r.failed, r.valid, r.hel}) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp hel=%b valid=%b fail=%b gap=%b, got tdata=%b",
                             r.hel, r.valid, r.failed, r.gap, d);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [39:0]          s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data = '0;

    helicity_scoreboard sb = new();
    bit    calm = 1'b0;
    int    sent = 0;
    int    cycles = 0;
    bit [31:0] now_t;
    bit [23:0] gen_seed;

    delayed_helicity_predictor dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 35);
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    task automatic send_event(bit [31:0] t, bit q, bit g, bit rd, bit s);
        bit ok;
        while (!calm && $urandom_range(99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, rd, g, q, t};
        s_axis_tuser <= s;
        do begin
            @(negedge i_clk);
            ok = s_axis_tready;
            @(posedge i_clk);
        end while (!ok);
        sb.note_event(t, q, g, rd, s);
        sent++;
    endtask

    task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [15:0] d);
        bit ok;
        s_axis_tvalid <= 1'b0;
        while (sb.results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
        sb.set_reg(idx, d);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_all(bit [7:0] dly, bit [1:0] sgn, bit [15:0] per, bit [15:0] tl);
        write_reg(CFG_IDX_DELAY, {8'($urandom), dly});
        write_reg(CFG_IDX_SIGN, {14'($urandom), sgn});
        write_reg(CFG_IDX_PERIOD, per);
        write_reg(CFG_IDX_TOL, tl);
    endtask

    // whole quads that follow the helicity sequence, with some noise mixed in
    task automatic run_quads(int n_items);
        int stop;
        longint p;
        bit rd;
        bit first;
        int n_in;
        stop = sent + n_items;
        p = sb.eff_period();
        while (sent < stop) begin
            if ($urandom_range(99) < 8) begin
                send_event($urandom, 1'($urandom), 1'($urandom), 1'($urandom),
                           1'($urandom));
            end else begin
                rd = gen_seed[23];
                gen_seed = gen_seed[23] ? ((gen_seed ^ TAPS) << 1) | 24'd1 : gen_seed << 1;
                if ($urandom_range(99) < 2) rd = ~rd;
                first = rd;
                send_event(now_t + 32'($urandom_range(0, int'(p / 8))), 1'b1,
                           $urandom_range(99) < 90, rd, 1'b0);
                n_in = $urandom_range(0, 3);
                for (int i = 1; i <= n_in; i++) begin
                    send_event(now_t + 32'(p * i / 4), 1'b0, $urandom_range(99) < 90,
                               (i == 2) ? first : 1'($urandom), $urandom_range(99) < 30);
                end
                now_t += 32'(p);
                if ($urandom_range(99) < 3) now_t += 32'(p * $urandom_range(1, 40));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes at reset settings, then a short quad train
        send_event(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0);
        send_event(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0);
        send_event(32'h0000_1000, 1'b0, 1'b1, 1'b1, 1'b1);
        send_event(32'h8000_0000, 1'b1, 1'b0, 1'b1, 1'b0);
        send_event(32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1);
        send_event(32'h5555_5555, 1'b1, 1'b1, 1'b1, 1'b0);
        send_event(32'hAAAA_AAAA, 1'b1, 1'b1, 1'b0, 1'b1);
        gen_seed = 24'($urandom) | 24'd1;
        now_t = 32'hFFFF_FE00;
        set_all(8'd0, 2'b01, 16'd4, 16'd0);
        run_quads(14);

        // nominal settings, timestamps start near the top of the range
        set_all(8'd0, 2'b01, 16'd100, 16'd20);
        now_t = 32'hFFFF_0000;
        run_quads(300);
        // largest delay, sign pattern acting as minus one, period of four
        set_all(8'd255, 2'b10, 16'd4, 16'd0);
        run_quads(200);
        set_all(8'd37, 2'b00, 16'd65535, 16'd65535);
        now_t = $urandom;
        run_quads(150);
        // zero period behaves as one tick
        set_all(8'd8, 2'b11, 16'd0, 16'd3);
        run_quads(100);
        set_all(8'($urandom), 2'($urandom), 16'($urandom_range(50, 2000)),
                16'($urandom_range(0, 60)));
        run_quads(150);
        calm = 1'b1;
        run_quads(150);
        calm = 1'b0;
        set_all(8'($urandom), 2'($urandom), 16'($urandom_range(20, 500)),
                16'($urandom_range(0, 30)));
        run_quads(150);

        s_axis_tvalid <= 1'b0;
        while (sb.results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.results_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
